/* design/orf_pkg.sv */
// ============================================================================
// orf_pkg: shared types and constants for the obstacle risk fusion block
// Holds the configuration bundle, message and level codes, and the vision
// code lookup tables.
// ============================================================================
package orf_pkg;

    // Depth window for a usable zone, exclusive at both ends.
    localparam logic [11:0] DEPTH_MIN_MM = 12'd10;
    localparam logic [11:0] DEPTH_MAX_MM = 12'd4000;
    // A frame with fewer valid zones than this counts as bad.
    localparam logic [6:0]  FEW_VALID    = 7'd5;
    localparam logic [6:0]  VALID_SAT    = 7'd127;
    localparam logic [7:0]  BAD_SAT      = 8'd255;
    // Ultrasonic readings at or below this are treated as no echo.
    localparam logic [15:0] ULTRA_MIN_MM = 16'd200;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EMERGENCY    = 3'd0;
    localparam logic [2:0] CFG_DANGER       = 3'd1;
    localparam logic [2:0] CFG_CAUTION      = 3'd2;
    localparam logic [2:0] CFG_OVERHEAD     = 3'd3;
    localparam logic [2:0] CFG_OVERHEAD_HLD = 3'd4;
    localparam logic [2:0] CFG_BAD_MAX      = 3'd5;
    localparam logic [2:0] CFG_REPEAT_HLD   = 3'd6;

    // Risk levels.
    localparam logic [2:0] LVL_NONE     = 3'd0;
    localparam logic [2:0] LVL_LOW      = 3'd1;
    localparam logic [2:0] LVL_MEDIUM   = 3'd2;
    localparam logic [2:0] LVL_HIGH     = 3'd3;
    localparam logic [2:0] LVL_CRITICAL = 3'd4;

    // Message codes.
    localparam logic [4:0] MSG_NONE        = 5'd0;
    localparam logic [4:0] MSG_STOP        = 5'd1;
    localparam logic [4:0] MSG_DESCENT     = 5'd2;
    localparam logic [4:0] MSG_STEP_UP     = 5'd3;
    localparam logic [4:0] MSG_MIND_HEAD   = 5'd4;
    localparam logic [4:0] MSG_OBST_AHEAD  = 5'd5;
    localparam logic [4:0] MSG_CAUTION     = 5'd6;
    localparam logic [4:0] MSG_RED_LIGHT   = 5'd7;
    localparam logic [4:0] MSG_OVERHEAD    = 5'd8;
    localparam logic [4:0] MSG_LATERAL     = 5'd9;
    localparam logic [4:0] MSG_XWALK_END   = 5'd10;
    localparam logic [4:0] MSG_STAIRS_DOWN = 5'd11;
    localparam logic [4:0] MSG_OBJECT      = 5'd12;
    localparam logic [4:0] MSG_PIT         = 5'd13;
    localparam logic [4:0] MSG_BUMP        = 5'd14;
    localparam logic [4:0] MSG_XWALK_NEAR  = 5'd15;
    localparam logic [4:0] MSG_OFF_TACTILE = 5'd16;
    localparam logic [4:0] MSG_GREEN_LIGHT = 5'd17;
    localparam logic [4:0] MSG_STAIRS_UP   = 5'd18;

    // Step codes.
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_DESC = 2'd1;

    // Vision codes.
    localparam logic [3:0] VIS_RED          = 4'd1;
    localparam logic [3:0] VIS_OVERHEAD     = 4'd2;
    localparam logic [3:0] VIS_LATERAL      = 4'd3;
    localparam logic [3:0] VIS_XWALK_END    = 4'd4;
    localparam logic [3:0] VIS_STAIRS_DOWN  = 4'd5;
    localparam logic [3:0] VIS_OBSTACLE     = 4'd6;
    localparam logic [3:0] VIS_PIT          = 4'd7;
    localparam logic [3:0] VIS_BUMP         = 4'd8;
    localparam logic [3:0] VIS_XWALK_NEAR   = 4'd9;
    localparam logic [3:0] VIS_TACTILE_WARN = 4'd10;
    localparam logic [3:0] VIS_OBST_NEAR    = 4'd11;
    localparam logic [3:0] VIS_GREEN        = 4'd12;
    localparam logic [3:0] VIS_STAIRS_UP    = 4'd13;

    // Configuration bundle.
    typedef struct packed {
        logic [11:0] emergency_mm;
        logic [11:0] danger_mm;
        logic [11:0] caution_mm;
        logic [11:0] overhead_mm;
        logic [15:0] overhead_hold_ms;
        logic [7:0]  bad_frames_max;
        logic [15:0] repeat_hold_ms;
    } cfg_t;

    // Risk level for a vision code.
    function automatic logic [2:0] vis_level(input logic [3:0] code);
        logic [2:0] lvl;
        case (code)
            VIS_RED, VIS_OVERHEAD, VIS_LATERAL, VIS_XWALK_END,
            VIS_STAIRS_DOWN, VIS_GREEN:                     lvl = LVL_HIGH;
            VIS_OBSTACLE, VIS_PIT, VIS_BUMP, VIS_XWALK_NEAR,
            VIS_TACTILE_WARN, VIS_OBST_NEAR:                lvl = LVL_MEDIUM;
            VIS_STAIRS_UP:                                  lvl = LVL_LOW;
            default:                                        lvl = LVL_NONE;
        endcase
        return lvl;
    endfunction

    // Message for a vision code.
    function automatic logic [4:0] vis_msg(input logic [3:0] code);
        logic [4:0] msg;
        case (code)
            VIS_RED:          msg = MSG_RED_LIGHT;
            VIS_OVERHEAD:     msg = MSG_OVERHEAD;
            VIS_LATERAL:      msg = MSG_LATERAL;
            VIS_XWALK_END:    msg = MSG_XWALK_END;
            VIS_STAIRS_DOWN:  msg = MSG_STAIRS_DOWN;
            VIS_OBSTACLE:     msg = MSG_OBJECT;
            VIS_PIT:          msg = MSG_PIT;
            VIS_BUMP:         msg = MSG_BUMP;
            VIS_XWALK_NEAR:   msg = MSG_XWALK_NEAR;
            VIS_TACTILE_WARN: msg = MSG_OFF_TACTILE;
            VIS_OBST_NEAR:    msg = MSG_OBJECT;
            VIS_GREEN:        msg = MSG_GREEN_LIGHT;
            VIS_STAIRS_UP:    msg = MSG_STAIRS_UP;
            default:          msg = MSG_NONE;
        endcase
        return msg;
    endfunction

endpackage

/* design/orf_if.sv */
// ============================================================================
// orf_if: valid/ready channels of the obstacle risk fusion block
// One interface for the zone sample stream and one for the result stream.
// ============================================================================
interface orf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] zone_mm;
    logic               last_zone;
    logic [15:0]        ultra_mm;
    logic [1:0]         step_code;
    logic [3:0]         vision_code;
    logic [31:0]        now_ms;

    modport source (
        output valid, zone_mm, last_zone, ultra_mm, step_code, vision_code, now_ms,
        input  ready
    );
    modport sink (
        input  valid, zone_mm, last_zone, ultra_mm, step_code, vision_code, now_ms,
        output ready
    );
endinterface

interface orf_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] risk_level;
    logic [4:0] message_code;

    modport source (
        output valid, risk_level, message_code,
        input  ready
    );
    modport sink (
        input  valid, risk_level, message_code,
        output ready
    );
endinterface

/* design/orf_cfg_regs.sv */
// ============================================================================
// orf_cfg_regs: configuration register file
// Write-only thresholds and hold times, loaded by index from the write port.
// ============================================================================
module orf_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output orf_pkg::cfg_t    cfg
);

    orf_pkg::cfg_t cfg_reg;
    orf_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes leave everything as is.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                orf_pkg::CFG_EMERGENCY:    cfg_next.emergency_mm     = cfg_data[11:0];
                orf_pkg::CFG_DANGER:       cfg_next.danger_mm        = cfg_data[11:0];
                orf_pkg::CFG_CAUTION:      cfg_next.caution_mm       = cfg_data[11:0];
                orf_pkg::CFG_OVERHEAD:     cfg_next.overhead_mm      = cfg_data[11:0];
                orf_pkg::CFG_OVERHEAD_HLD: cfg_next.overhead_hold_ms = cfg_data;
                orf_pkg::CFG_BAD_MAX:      cfg_next.bad_frames_max   = cfg_data[7:0];
                orf_pkg::CFG_REPEAT_HLD:   cfg_next.repeat_hold_ms   = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file with its default thresholds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.emergency_mm     <= 12'd500;
            cfg_reg.danger_mm        <= 12'd1000;
            cfg_reg.caution_mm       <= 12'd2000;
            cfg_reg.overhead_mm      <= 12'd800;
            cfg_reg.overhead_hold_ms <= 16'd500;
            cfg_reg.bad_frames_max   <= 8'd5;
            cfg_reg.repeat_hold_ms   <= 16'd3000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/orf_frame.sv */
// ============================================================================
// orf_frame: per-frame depth accumulation
// Tracks the nearest valid zone and the valid-zone count, closes the frame on
// the last zone and keeps the saturating bad-frame count.
// ============================================================================
module orf_frame (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic signed [15:0] zone_mm,
    input  logic               last_zone,
    input  logic [7:0]         bad_frames_max,
    output logic [11:0]        closest_mm
);

    logic [11:0] nearest_reg, nearest_next;
    logic [6:0]  valid_zones_reg, valid_zones_next;
    logic [7:0]  bad_frames_reg, bad_frames_next;

    logic        zone_ok;
    logic [11:0] nearest_upd;
    logic [6:0]  valid_upd;
    logic [7:0]  bad_upd;

    // Fold the current zone into the running minimum and count.
    always_comb
    begin
        zone_ok = (zone_mm > $signed({4'd0, orf_pkg::DEPTH_MIN_MM}))
               && (zone_mm < $signed({4'd0, orf_pkg::DEPTH_MAX_MM}));
        nearest_upd = nearest_reg;
        if (zone_ok && (zone_mm[11:0] < nearest_reg))
        begin
            nearest_upd = zone_mm[11:0];
        end
        valid_upd = valid_zones_reg;
        if (zone_ok && (valid_zones_reg != orf_pkg::VALID_SAT))
        begin
            valid_upd = valid_zones_reg + 7'd1;
        end
    end

    // Frame close: bad-frame bookkeeping and the depth handed to the decision.
    always_comb
    begin
        if (valid_upd < orf_pkg::FEW_VALID)
        begin
            bad_upd = (bad_frames_reg != orf_pkg::BAD_SAT) ? bad_frames_reg + 8'd1
                                                           : bad_frames_reg;
        end
        else
        begin
            bad_upd = 8'd0;
        end
        if ((bad_upd > bad_frames_max) || (nearest_upd >= orf_pkg::DEPTH_MAX_MM))
        begin
            closest_mm = 12'd0;
        end
        else
        begin
            closest_mm = nearest_upd;
        end
    end

    // Next state: accumulate mid-frame, restart after the last zone.
    always_comb
    begin
        nearest_next     = nearest_reg;
        valid_zones_next = valid_zones_reg;
        bad_frames_next  = bad_frames_reg;
        if (en)
        begin
            if (last_zone)
            begin
                nearest_next     = orf_pkg::DEPTH_MAX_MM;
                valid_zones_next = 7'd0;
                bad_frames_next  = bad_upd;
            end
            else
            begin
                nearest_next     = nearest_upd;
                valid_zones_next = valid_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nearest_reg     <= orf_pkg::DEPTH_MAX_MM;
            valid_zones_reg <= 7'd0;
            bad_frames_reg  <= 8'd0;
        end
        else
        begin
            nearest_reg     <= nearest_next;
            valid_zones_reg <= valid_zones_next;
            bad_frames_reg  <= bad_frames_next;
        end
    end

    // A closed frame always restarts from an empty accumulator.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (en && last_zone) |=> (valid_zones_reg == 7'd0
                               && nearest_reg == orf_pkg::DEPTH_MAX_MM))
        else $error("frame accumulator not cleared after last zone");

endmodule

/* design/orf_decide.sv */
// ============================================================================
// orf_decide: risk decision and repeat suppression
// Picks one message in priority order, runs the overhead persistence timer and
// drops a message that repeats inside the hold window.
// ============================================================================
module orf_decide (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  orf_pkg::cfg_t cfg,
    input  logic [11:0]   closest_mm,
    input  logic [15:0]   ultra_mm,
    input  logic [1:0]    step_code,
    input  logic [3:0]    vision_code,
    input  logic [31:0]   now_ms,
    output logic [2:0]    risk_level,
    output logic [4:0]    message_code
);

    logic        oh_armed_reg, oh_armed_next;
    logic [31:0] oh_since_reg, oh_since_next;
    logic [4:0]  last_msg_reg, last_msg_next;
    logic [31:0] last_spoken_reg, last_spoken_next;

    logic        have_depth;
    logic        ultra_on;
    logic        oh_cond;
    logic [31:0] oh_since_eff;
    logic [31:0] oh_elapsed;
    logic        oh_fire;
    logic        oh_update;
    logic        oh_armed_upd;
    logic [2:0]  lvl;
    logic [4:0]  msg;
    logic [31:0] since_spoken;
    logic        suppress;

    // Overhead timer: arm on first sight, fire once the hold has passed.
    always_comb
    begin
        have_depth   = closest_mm > orf_pkg::DEPTH_MIN_MM;
        ultra_on     = ultra_mm > orf_pkg::ULTRA_MIN_MM;
        oh_cond      = ultra_on && (ultra_mm < {4'd0, cfg.overhead_mm});
        oh_since_eff = oh_armed_reg ? oh_since_reg : now_ms;
        oh_elapsed   = now_ms - oh_since_eff;
        oh_fire      = oh_cond && (oh_elapsed > {16'd0, cfg.overhead_hold_ms});
        oh_armed_upd = oh_cond && !oh_fire;
    end

    // Priority chain: emergency, step, overhead, ultrasonic zones, vision.
    always_comb
    begin
        oh_update = 1'b0;
        if (have_depth && (closest_mm < cfg.emergency_mm))
        begin
            lvl = orf_pkg::LVL_CRITICAL;
            msg = orf_pkg::MSG_STOP;
        end
        else if (step_code != orf_pkg::STEP_NONE)
        begin
            lvl = orf_pkg::LVL_HIGH;
            msg = (step_code == orf_pkg::STEP_DESC) ? orf_pkg::MSG_DESCENT
                                                    : orf_pkg::MSG_STEP_UP;
        end
        else
        begin
            oh_update = 1'b1;
            if (oh_fire)
            begin
                lvl = orf_pkg::LVL_HIGH;
                msg = orf_pkg::MSG_MIND_HEAD;
            end
            else if (ultra_on && (ultra_mm < {4'd0, cfg.danger_mm}))
            begin
                lvl = orf_pkg::LVL_CRITICAL;
                msg = orf_pkg::MSG_OBST_AHEAD;
            end
            else if ((ultra_mm >= {4'd0, cfg.danger_mm})
                  && (ultra_mm < {4'd0, cfg.caution_mm}))
            begin
                if (have_depth && (closest_mm < cfg.danger_mm))
                begin
                    lvl = orf_pkg::LVL_HIGH;
                    msg = orf_pkg::MSG_OBST_AHEAD;
                end
                else
                begin
                    lvl = orf_pkg::LVL_MEDIUM;
                    msg = orf_pkg::MSG_CAUTION;
                end
            end
            else
            begin
                lvl = orf_pkg::vis_level(vision_code);
                msg = orf_pkg::vis_msg(vision_code);
            end
        end
    end

    // Repeat filter on the chosen message.
    always_comb
    begin
        since_spoken = now_ms - last_spoken_reg;
        suppress = (msg != orf_pkg::MSG_NONE) && (msg == last_msg_reg)
                && (since_spoken < {16'd0, cfg.repeat_hold_ms});
        if (suppress || (msg == orf_pkg::MSG_NONE))
        begin
            risk_level   = orf_pkg::LVL_NONE;
            message_code = orf_pkg::MSG_NONE;
        end
        else
        begin
            risk_level   = lvl;
            message_code = msg;
        end
    end

    // State updates happen only when a frame closes.
    always_comb
    begin
        oh_armed_next    = oh_armed_reg;
        oh_since_next    = oh_since_reg;
        last_msg_next    = last_msg_reg;
        last_spoken_next = last_spoken_reg;
        if (en)
        begin
            if (oh_update)
            begin
                oh_armed_next = oh_armed_upd;
                if (oh_cond)
                begin
                    oh_since_next = oh_since_eff;
                end
            end
            if (message_code != orf_pkg::MSG_NONE)
            begin
                last_msg_next    = message_code;
                last_spoken_next = now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oh_armed_reg    <= 1'b0;
            oh_since_reg    <= 32'd0;
            last_msg_reg    <= orf_pkg::MSG_NONE;
            last_spoken_reg <= 32'd0;
        end
        else
        begin
            oh_armed_reg    <= oh_armed_next;
            oh_since_reg    <= oh_since_next;
            last_msg_reg    <= last_msg_next;
            last_spoken_reg <= last_spoken_next;
        end
    end

    // A suppressed repeat leaves the spoken history untouched.
    a_suppress_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (en && suppress) |=> ($stable(last_msg_reg) && $stable(last_spoken_reg)))
        else $error("suppressed message changed the repeat history");

endmodule

/* design/obstacle_risk_fusion.sv */
// A zone beat is registered on acceptance; the frame's result is loaded
// into the result register as the last zone leaves the input register,
// which it does only once the result register has room for that result.
// Throughput: one zone beat per cycle; the input register and the result
// register decouple the two sides, so only a last-zone beat waits for a full
// result register. Reset clears all frame, timer and repeat state and loads
// the default thresholds; no clearing pass is needed.
// ============================================================================
// obstacle_risk_fusion: depth, ultrasonic and vision risk fusion
// Streams depth zones into a frame accumulator and, on each frame end,
// issues one risk level and spoken message code.
// ============================================================================
module obstacle_risk_fusion (
    input  logic               clk,
    input  logic               rst_n,
    orf_sample_if.sink         sample,
    orf_result_if.source       result,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    orf_pkg::cfg_t cfg;

    // Input register.
    logic               in_valid_reg, in_valid_next;
    logic signed [15:0] zone_reg;
    logic               last_reg;
    logic [15:0]        ultra_reg;
    logic [1:0]         step_reg;
    logic [3:0]         vision_reg;
    logic [31:0]        now_reg;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         level_reg;
    logic [4:0]         msg_reg;

    logic               advance;
    logic               take;
    logic               close;
    logic [11:0]        closest_mm;
    logic [2:0]         level_calc;
    logic [4:0]         msg_calc;

    orf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A mid-frame beat always moves on; a last beat needs room for its result.
    assign advance      = in_valid_reg && (!last_reg || !out_valid_reg || result.ready);
    assign close        = advance && last_reg;
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    orf_frame u_frame (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .zone_mm        (zone_reg),
        .last_zone      (last_reg),
        .bad_frames_max (cfg.bad_frames_max),
        .closest_mm     (closest_mm)
    );

    orf_decide u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (close),
        .cfg          (cfg),
        .closest_mm   (closest_mm),
        .ultra_mm     (ultra_reg),
        .step_code    (step_reg),
        .vision_code  (vision_reg),
        .now_ms       (now_reg),
        .risk_level   (level_calc),
        .message_code (msg_calc)
    );

    // Handshake state of both registers.
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (close)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload capture; no reset needed.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            zone_reg   <= sample.zone_mm;
            last_reg   <= sample.last_zone;
            ultra_reg  <= sample.ultra_mm;
            step_reg   <= sample.step_code;
            vision_reg <= sample.vision_code;
            now_reg    <= sample.now_ms;
        end
        if (close)
        begin
            level_reg <= level_calc;
            msg_reg   <= msg_calc;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.risk_level   = level_reg;
    assign result.message_code = msg_reg;

    // A waiting result must not be overwritten by the next frame end.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && in_valid_reg && last_reg) |-> !advance)
        else $error("result register overwritten while stalled");

    // Silence always carries level none.
    a_silent_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && msg_reg == orf_pkg::MSG_NONE) |-> (level_reg == orf_pkg::LVL_NONE))
        else $error("nonzero risk level without a message");

    // An empty input register always takes a beat.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> sample.ready)
        else $error("input register empty but not ready");

endmodule
